@@ design/vrap_pkg.sv @@
`timescale 1ns / 1ps

package vrap_pkg;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [2:0] PORT_CTRL    = 3'd0;
  localparam logic [2:0] PORT_ADDR_LO = 3'd1;
  localparam logic [2:0] PORT_ADDR_HI = 3'd2;
  localparam logic [2:0] PORT_DATA_LO = 3'd3;
  localparam logic [2:0] PORT_DATA_HI = 3'd4;

  localparam logic [1:0] REMAP_NONE = 2'd0;
  localparam logic [1:0] REMAP_8    = 2'd1;
  localparam logic [1:0] REMAP_9    = 2'd2;
  localparam logic [1:0] REMAP_10   = 2'd3;

  typedef logic [15:0] word_t;

  function automatic logic [7:0] step_of(input logic [1:0] sel);
    logic [7:0] s;
    unique case (sel)
      2'd0:    s = 8'd1;
      2'd1:    s = 8'd32;
      default: s = 8'd128;
    endcase
    return s;
  endfunction

  function automatic word_t remap(input word_t a, input logic [1:0] mode);
    word_t r;
    unique case (mode)
      REMAP_8:  r = {a[15:8], a[4:0], a[7:5]};
      REMAP_9:  r = {a[15:9], a[5:0], a[8:6]};
      REMAP_10: r = {a[15:10], a[6:0], a[9:7]};
      default:  r = a;
    endcase
    return r;
  endfunction

endpackage

@@ design/vrap_if.sv @@
`timescale 1ns / 1ps

interface vrap_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] port;
  logic [7:0] wdata;
  logic       access_blocked;
  logic [7:0] bus_value;

  modport source (output valid, kind, port, wdata, access_blocked, bus_value, input ready);
  modport sink (input valid, kind, port, wdata, access_blocked, bus_value, output ready);
endinterface

interface vrap_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

@@ design/video_ram_access_port.sv @@
`timescale 1ns / 1ps
// A result item is registered in the cycle after its input item is accepted.
// One item per cycle unless the output stalls; address writes and data reads that
// advance the pointer drop ready while the prefetch latch waits on the RAM read.
// Reset (synchronous, active low): pointer, prefetch latch, control and open bus
// clear, step returns to one; the word store is undefined until written.
module video_ram_access_port
  import vrap_pkg::*;
#(
  parameter int STORE_ADDR_BITS = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  vrap_in_if.sink         in_ch,
  vrap_out_if.source      out_ch
);

  localparam int StoreDepth = 1 << STORE_ADDR_BITS;

  word_t      ptr_r, ptr_nxt;
  word_t      prefetch_r, prefetch_nxt;
  logic [7:0] step_r, step_nxt;
  logic [1:0] remap_r, remap_nxt;
  logic       adv_hi_r, adv_hi_nxt;
  logic [7:0] open_bus_r, open_bus_nxt;
  logic       refill_r, refill_nxt;
  logic       blocked_r, blocked_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  word_t                      access_ptr;
  word_t                      mapped;
  logic [STORE_ADDR_BITS-1:0] ram_addr;
  logic                       we_lo, we_hi;
  logic [7:0]                 rd_lo, rd_hi;
  logic                       accept;
  logic                       high_sel;

  assign in_ch.ready  = !refill_r && (!out_valid_r || out_ch.ready);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign high_sel     = (in_ch.port == PORT_DATA_HI);

  always_comb begin
    access_ptr = ptr_r;
    if (in_ch.kind == KIND_WRITE && in_ch.port == PORT_ADDR_LO) begin
      access_ptr = {ptr_r[15:8], in_ch.wdata};
    end else if (in_ch.kind == KIND_WRITE && in_ch.port == PORT_ADDR_HI) begin
      access_ptr = {in_ch.wdata, ptr_r[7:0]};
    end
  end

  assign mapped   = remap(access_ptr, remap_r);
  assign ram_addr = mapped[STORE_ADDR_BITS-1:0];

  always_comb begin
    ptr_nxt       = ptr_r;
    prefetch_nxt  = prefetch_r;
    step_nxt      = step_r;
    remap_nxt     = remap_r;
    adv_hi_nxt    = adv_hi_r;
    open_bus_nxt  = open_bus_r;
    refill_nxt    = 1'b0;
    blocked_nxt   = blocked_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    we_lo         = 1'b0;
    we_hi         = 1'b0;

    if (refill_r) begin
      prefetch_nxt = blocked_r ? '0 : {rd_hi, rd_lo};
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      blocked_nxt   = in_ch.access_blocked;
      if (in_ch.kind == KIND_WRITE) begin
        unique case (in_ch.port)
          PORT_CTRL: begin
            step_nxt   = step_of(in_ch.wdata[1:0]);
            remap_nxt  = in_ch.wdata[3:2];
            adv_hi_nxt = in_ch.wdata[7];
          end
          PORT_ADDR_LO, PORT_ADDR_HI: begin
            ptr_nxt    = access_ptr;
            refill_nxt = 1'b1;
          end
          PORT_DATA_LO, PORT_DATA_HI: begin
            we_lo = !in_ch.access_blocked && !high_sel;
            we_hi = !in_ch.access_blocked && high_sel;
            if (adv_hi_r == high_sel) begin
              ptr_nxt = ptr_r + {8'd0, step_r};
            end
          end
          default: ;
        endcase
      end else begin
        unique case (in_ch.port)
          PORT_ADDR_HI: out_data_nxt = in_ch.bus_value;
          PORT_DATA_LO, PORT_DATA_HI: begin
            out_data_nxt = high_sel ? prefetch_r[15:8] : prefetch_r[7:0];
            open_bus_nxt = out_data_nxt;
            if (adv_hi_r == high_sel) begin
              refill_nxt = 1'b1;
              ptr_nxt    = ptr_r + {8'd0, step_r};
            end
          end
          default: out_data_nxt = open_bus_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      prefetch_r  <= '0;
      step_r      <= 8'd1;
      remap_r     <= REMAP_NONE;
      adv_hi_r    <= 1'b0;
      open_bus_r  <= '0;
      refill_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      prefetch_r  <= prefetch_nxt;
      step_r      <= step_nxt;
      remap_r     <= remap_nxt;
      adv_hi_r    <= adv_hi_nxt;
      open_bus_r  <= open_bus_nxt;
      refill_r    <= refill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blocked_r  <= blocked_nxt;
    out_data_r <= out_data_nxt;
  end

  vrap_ram #(
    .WIDTH(8),
    .DEPTH(StoreDepth)
  ) u_ram_lo (
    .clk   (clk),
    .we    (we_lo),
    .addr  (ram_addr),
    .wdata (in_ch.wdata),
    .rdata (rd_lo)
  );

  vrap_ram #(
    .WIDTH(8),
    .DEPTH(StoreDepth)
  ) u_ram_hi (
    .clk   (clk),
    .we    (we_hi),
    .addr  (ram_addr),
    .wdata (in_ch.wdata),
    .rdata (rd_hi)
  );

endmodule

@@ design/vrap_ram.sv @@
`timescale 1ns / 1ps

module vrap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ dv/vrap_checker.sv @@
`timescale 1ns / 1ps

module vrap_checker
  import vrap_pkg::*;
#(
  parameter int STORE_ADDR_BITS = 15
) (
  input  logic clk,
  input  logic rst_n,
  vrap_in_if   mon_in,
  vrap_out_if  mon_out,
  output int   fail_count,
  output int   pending
);

  localparam int unsigned WORDS = 1 << STORE_ADDR_BITS;

  word_t      vram [WORDS];
  word_t      ptr;
  word_t      pf_word;
  logic [7:0] step_amt;
  logic [1:0] mode;
  logic       adv_high;
  logic [7:0] last_byte;
  logic [7:0] read_q[$];

  function automatic int unsigned vram_index(input word_t a, input logic [1:0] m);
    word_t r;
    case (m)
      REMAP_8:  r = (a & 16'hff00) | ((a & 16'h001f) << 3) | ((a >> 5) & 16'h0007);
      REMAP_9:  r = (a & 16'hfe00) | ((a & 16'h003f) << 3) | ((a >> 6) & 16'h0007);
      REMAP_10: r = (a & 16'hfc00) | ((a & 16'h007f) << 3) | ((a >> 7) & 16'h0007);
      default:  r = a;
    endcase
    return int'(r) & (WORDS - 1);
  endfunction

  function automatic word_t refill(input logic blk);
    return blk ? 16'h0000 : vram[vram_index(ptr, mode)];
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    if (fail_count < 40)
      $display("%0t: %s: read_data %02h, predicted %02h", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one accepted access to the predicted state and return the byte it reads.
  task automatic apply_access(input logic k, input logic [2:0] p, input logic [7:0] d,
                              input logic blk, input logic [7:0] bus,
                              output logic [7:0] rd);
    logic        hi;
    int unsigned at;
    hi = (p == PORT_DATA_HI);
    rd = 8'h00;
    if (k == KIND_WRITE) begin
      case (p)
        PORT_CTRL: begin
          case (d[1:0])
            2'd0:    step_amt = 8'd1;
            2'd1:    step_amt = 8'd32;
            default: step_amt = 8'd128;
          endcase
          mode = d[3:2];
          adv_high = d[7];
        end
        PORT_ADDR_LO: begin
          ptr[7:0] = d;
          pf_word = refill(blk);
        end
        PORT_ADDR_HI: begin
          ptr[15:8] = d;
          pf_word = refill(blk);
        end
        PORT_DATA_LO, PORT_DATA_HI: begin
          at = vram_index(ptr, mode);
          if (!blk) begin
            if (hi) vram[at][15:8] = d;
            else vram[at][7:0] = d;
          end
          if (adv_high == hi) ptr = ptr + step_amt;
        end
        default: ;
      endcase
    end else begin
      case (p)
        PORT_ADDR_HI: rd = bus;
        PORT_DATA_LO, PORT_DATA_HI: begin
          rd = hi ? pf_word[15:8] : pf_word[7:0];
          if (adv_high == hi) begin
            pf_word = refill(blk);
            ptr = ptr + step_amt;
          end
          last_byte = rd;
        end
        default: rd = last_byte;
      endcase
    end
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    logic [7:0] got;
    if (!rst_n) begin
      foreach (vram[i]) vram[i] = '0;
      ptr = '0;
      pf_word = '0;
      step_amt = 8'd1;
      mode = REMAP_NONE;
      adv_high = 1'b0;
      last_byte = '0;
      read_q.delete();
      fail_count = 0;
    end else begin
      if (mon_out.valid && mon_out.ready) begin
        if (read_q.size() == 0) begin
          report("unexpected item", mon_out.read_data, 8'h00);
        end else begin
          want = read_q.pop_front();
          if (mon_out.read_data !== want) report("mismatch", mon_out.read_data, want);
        end
      end
      if (mon_in.valid && mon_in.ready) begin
        apply_access(mon_in.kind, mon_in.port, mon_in.wdata, mon_in.access_blocked,
                     mon_in.bus_value, got);
        read_q.push_back(got);
      end
    end
    pending = read_q.size();
  end

endmodule

@@ dv/tb_video_ram_access_port.sv @@
`timescale 1ns / 1ps

module tb_video_ram_access_port;
  import vrap_pkg::*;

  localparam int STORE_ADDR_BITS = 15;
  localparam int unsigned WORDS = 1 << STORE_ADDR_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;

  vrap_in_if  in_ch();
  vrap_out_if out_ch();

  video_ram_access_port #(.STORE_ADDR_BITS(STORE_ADDR_BITS)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  vrap_checker #(.STORE_ADDR_BITS(STORE_ADDR_BITS)) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .mon_in    (in_ch),
    .mon_out   (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_len = 0;
  int   sent = 0;

  // Per-byte record of which store bytes hold defined data, used to keep
  // reads away from bytes that were never written.
  logic [1:0] byte_ok [WORDS];
  logic [1:0] latch_ok = 2'b11;
  word_t      s_ptr = '0;
  logic [7:0] s_step = 8'd1;
  logic [1:0] s_mode = REMAP_NONE;
  logic       s_adv_high = 1'b0;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned slot();
    return int'(remap(s_ptr, s_mode)) & (WORDS - 1);
  endfunction

  function automatic logic [1:0] latch_fill(input logic blk);
    return blk ? 2'b11 : byte_ok[slot()];
  endfunction

  task automatic track(input logic k, input logic [2:0] p, input logic [7:0] d,
                       input logic blk);
    logic hi;
    hi = (p == PORT_DATA_HI);
    if (k == KIND_WRITE) begin
      case (p)
        PORT_CTRL: begin
          s_step = step_of(d[1:0]);
          s_mode = d[3:2];
          s_adv_high = d[7];
        end
        PORT_ADDR_LO: begin
          s_ptr[7:0] = d;
          latch_ok = latch_fill(blk);
        end
        PORT_ADDR_HI: begin
          s_ptr[15:8] = d;
          latch_ok = latch_fill(blk);
        end
        PORT_DATA_LO, PORT_DATA_HI: begin
          if (!blk) byte_ok[slot()][hi] = 1'b1;
          if (s_adv_high == hi) s_ptr = s_ptr + s_step;
        end
        default: ;
      endcase
    end else if ((p == PORT_DATA_LO || p == PORT_DATA_HI) && s_adv_high == hi) begin
      latch_ok = latch_fill(blk);
      s_ptr = s_ptr + s_step;
    end
  endtask

  task automatic put(input logic k, input logic [2:0] p, input logic [7:0] d,
                     input logic blk, input logic [7:0] bus);
    logic kk;
    while (chance(idle_pct)) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    kk = k;
    // turn a read of an undefined latch byte into a write of that byte
    if (k == KIND_READ && (p == PORT_DATA_LO || p == PORT_DATA_HI) &&
        !latch_ok[p == PORT_DATA_HI])
      kk = KIND_WRITE;
    in_ch.valid = 1'b1;
    in_ch.kind = kk;
    in_ch.port = p;
    in_ch.wdata = d;
    in_ch.access_blocked = blk;
    in_ch.bus_value = bus;
    do @(posedge clk); while (!in_ch.ready);
    track(kk, p, d, blk);
    sent++;
    @(negedge clk);
  endtask

  task automatic noise_item();
    put(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom),
        1'($urandom_range(1)), 8'($urandom));
  endtask

  // Write a run of words, reload the address, read the run back.
  task automatic word_burst();
    logic [7:0] ctl;
    word_t      base;
    int         n;
    logic [2:0] lead;
    logic [2:0] trail;
    ctl = 8'($urandom);
    base = 16'($urandom);
    n = int'($urandom_range(1, 8));
    lead = ctl[7] ? PORT_DATA_LO : PORT_DATA_HI;
    trail = ctl[7] ? PORT_DATA_HI : PORT_DATA_LO;
    put(KIND_WRITE, PORT_CTRL, ctl, chance(50), 8'($urandom));
    put(KIND_WRITE, PORT_ADDR_LO, base[7:0], chance(5), 8'($urandom));
    put(KIND_WRITE, PORT_ADDR_HI, base[15:8], chance(5), 8'($urandom));
    for (int i = 0; i < n; i++) begin
      if (chance(8)) noise_item();
      put(KIND_WRITE, lead, 8'($urandom), chance(5), 8'($urandom));
      put(KIND_WRITE, trail, 8'($urandom), chance(5), 8'($urandom));
    end
    put(KIND_WRITE, PORT_ADDR_HI, base[15:8], chance(3), 8'($urandom));
    put(KIND_WRITE, PORT_ADDR_LO, base[7:0], chance(3), 8'($urandom));
    for (int i = 0; i < n; i++) begin
      if (chance(8)) noise_item();
      put(KIND_READ, lead, 8'($urandom), chance(5), 8'($urandom));
      put(KIND_READ, trail, 8'($urandom), chance(5), 8'($urandom));
    end
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int n_items, input int idle, input int stall);
    int target;
    target = sent + n_items;
    idle_pct = idle;
    stall_pct = stall;
    while (sent < target) begin
      if (chance(20)) noise_item();
      else word_burst();
    end
    drain();
  endtask

  initial begin
    foreach (byte_ok[i]) byte_ok[i] = 2'b00;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WRITE;
    in_ch.port = PORT_CTRL;
    in_ch.wdata = '0;
    in_ch.access_blocked = 1'b0;
    in_ch.bus_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    put(KIND_READ, PORT_CTRL, 8'h00, 1'b0, 8'h00);
    put(KIND_READ, PORT_ADDR_LO, 8'hff, 1'b0, 8'hff);
    put(KIND_READ, PORT_ADDR_HI, 8'h00, 1'b0, 8'ha5);
    put(KIND_READ, PORT_ADDR_HI, 8'h00, 1'b0, 8'h00);
    put(KIND_READ, 3'd7, 8'h00, 1'b1, 8'hff);
    put(KIND_WRITE, PORT_CTRL, 8'h80, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_ADDR_HI, 8'hff, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_ADDR_LO, 8'hff, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_DATA_LO, 8'h00, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_DATA_HI, 8'hff, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_ADDR_LO, 8'hff, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_ADDR_HI, 8'hff, 1'b0, 8'h00);
    put(KIND_READ, PORT_DATA_LO, 8'h00, 1'b0, 8'h00);
    put(KIND_READ, PORT_DATA_HI, 8'h00, 1'b0, 8'h00);
    put(KIND_READ, PORT_CTRL, 8'h00, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_CTRL, 8'h7f, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_DATA_LO, 8'hff, 1'b1, 8'h00);
    put(KIND_WRITE, PORT_CTRL, 8'h0d, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_CTRL, 8'h06, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_CTRL, 8'h89, 1'b0, 8'h00);
    put(KIND_WRITE, PORT_ADDR_LO, 8'h00, 1'b1, 8'h00);
    put(KIND_READ, PORT_DATA_LO, 8'h00, 1'b1, 8'h00);
    put(KIND_READ, PORT_DATA_HI, 8'h00, 1'b1, 8'h00);
    put(KIND_WRITE, 3'd5, 8'hff, 1'b0, 8'hff);
    put(KIND_WRITE, PORT_CTRL, 8'h00, 1'b0, 8'h00);
    drain();

    run_phase(400, 0, 0);
    run_phase(300, 81, 0);
    run_phase(300, 0, 81);
    hold_len = 300;
    hold_req = 1'b1;
    run_phase(450, 7, 7);

    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
